// ===== rtl/core/masked_permutation_aead_engine_top_defines.svh =====
// Assertion macros shared by the engine top level.
`ifndef MASKED_PERMUTATION_AEAD_ENGINE_TOP_DEFINES_SVH
`define MASKED_PERMUTATION_AEAD_ENGINE_TOP_DEFINES_SVH

// check out of reset
`define OPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check through reset as well
`define OPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/opp_pkg.sv =====
// Shared types, constants and mask/padding functions for the AEAD engine.
package opp_pkg;

  localparam int DOUBLE_ROUNDS = 4;
  localparam int TAG_WORDS     = 4;
  localparam int RoundW        = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_HDR   = 3'd1;
  localparam logic [2:0] CMD_ENC   = 3'd2;
  localparam logic [2:0] CMD_DEC   = 3'd3;
  localparam logic [2:0] CMD_FIN   = 3'd4;
  localparam logic [2:0] CMD_TAG   = 3'd5;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_TAG   = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE0 = 3'd4;
  localparam logic [2:0] REG_NONCE1 = 3'd5;

  typedef logic [63:0] word_t;
  typedef word_t [15:0] blk_t;

  typedef struct packed {
    word_t [3:0] key;
    word_t [1:0] nonce;
  } cfg_t;

  typedef struct packed {
    word_t       out_word;
    logic [3:0]  out_bytes;
    logic [1:0]  result_kind;
    logic        tag_match;
    logic        last_result;
  } out_item_t;

  function automatic word_t rotl(word_t x, int c);
    return (x << c) | (x >> (64 - c));
  endfunction

  function automatic word_t rotr(word_t x, int c);
    return (x >> c) | (x << (64 - c));
  endfunction

  // state word index of lane j in column or diagonal step k
  function automatic logic [3:0] qidx(logic [2:0] k, logic [1:0] j);
    logic [1:0] off;
    off = k[2] ? (k[1:0] + j) : k[1:0];
    return {j, off};
  endfunction

  function automatic word_t phi(blk_t m, int a, int b);
    return rotl(m[a], 53) ^ (m[b] << 13);
  endfunction

  function automatic blk_t alpha(blk_t m);
    blk_t r;
    for (int i = 0; i < 15; i++) r[i] = m[i + 1];
    r[15] = phi(m, 0, 5);
    return r;
  endfunction

  function automatic blk_t beta(blk_t m);
    blk_t r;
    for (int i = 0; i < 15; i++) r[i] = m[i] ^ m[i + 1];
    r[15] = m[15] ^ phi(m, 0, 5);
    return r;
  endfunction

  function automatic blk_t gamma(blk_t m);
    blk_t r;
    word_t t0;
    word_t t1;
    t0 = phi(m, 0, 5);
    t1 = phi(m, 1, 6);
    for (int i = 0; i < 14; i++) r[i] = m[i] ^ m[i + 1] ^ m[i + 2];
    r[14] = m[14] ^ m[15] ^ t0;
    r[15] = m[15] ^ t0 ^ t1;
    return r;
  endfunction

  function automatic word_t byte_mask(logic [3:0] bytes);
    word_t m;
    for (int i = 0; i < 8; i++) m[8*i +: 8] = (4'(i) < bytes) ? 8'hFF : 8'h00;
    return m;
  endfunction

  // valid bytes of word i in a block of n bytes, capped at eight
  function automatic logic [3:0] word_bytes(logic [7:0] n, logic [3:0] i);
    logic [7:0] d;
    d = n - {1'b0, i, 3'b000};
    return (d >= 8'd8) ? 4'd8 : d[3:0];
  endfunction

  function automatic blk_t pad(blk_t b, logic [7:0] n);
    blk_t p;
    for (int i = 0; i < 16; i++) p[i] = (8'(8 * i) < n) ? b[i] : '0;
    p[n[6:3]][{n[2:0], 3'b000}] = 1'b1;
    return p;
  endfunction

endpackage

// ===== rtl/core/opp_if.sv =====
// Stream interfaces for command items and result items.
interface opp_in_if import opp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  word_t      data_word;
  logic [3:0] byte_count;
  logic       last_word;

  modport source(output valid, cmd, data_word, byte_count, last_word, input ready);
  modport sink(input valid, cmd, data_word, byte_count, last_word, output ready);
endinterface

interface opp_out_if import opp_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      out_word;
  logic [3:0] out_bytes;
  logic [1:0] result_kind;
  logic       tag_match;
  logic       last_result;

  modport source(output valid, out_word, out_bytes, result_kind, tag_match, last_result,
                 input ready);
  modport sink(input valid, out_word, out_bytes, result_kind, tag_match, last_result,
               output ready);
endinterface

// ===== rtl/core/opp_round.sv =====
// Half quarter-round unit, forward or inverse, shared by every permutation step.
module opp_round import opp_pkg::*; (
  input  word_t a,
  input  word_t b,
  input  word_t c,
  input  word_t d,
  input  logic  inv,
  input  logic  hi,
  output word_t a_o,
  output word_t b_o,
  output word_t c_o,
  output word_t d_o
);

  word_t fa, fb, fc, fd, xd, xb;
  word_t ib, ic, id, ia;

  always_comb begin
    fa = a + b;
    xd = d ^ fa;
    fd = hi ? rotr(xd, 16) : rotr(xd, 32);
    fc = c + fd;
    xb = b ^ fc;
    fb = hi ? rotr(xb, 63) : rotr(xb, 24);

    ib = (hi ? rotl(b, 63) : rotl(b, 24)) ^ c;
    ic = c - d;
    id = (hi ? rotl(d, 16) : rotl(d, 32)) ^ a;
    ia = a - ib;

    a_o = inv ? ia : fa;
    b_o = inv ? ib : fb;
    c_o = inv ? ic : fc;
    d_o = inv ? id : fd;
  end

endmodule

// ===== rtl/core/opp_core.sv =====
// Sequencer, mask and sum state, and result register of the AEAD engine.
module opp_core import opp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  opp_in_if.sink   in_ch,
  opp_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_BETA   = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_PERM   = 3'd4;
  localparam logic [2:0] S_POST   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_HFULL = 3'd1;
  localparam logic [2:0] OP_HPART = 3'd2;
  localparam logic [2:0] OP_MFULL = 3'd3;
  localparam logic [2:0] OP_MPART = 3'd4;
  localparam logic [2:0] OP_FIN   = 3'd5;
  localparam logic [2:0] OP_TCHK  = 3'd6;

  logic [2:0]        state;
  logic [2:0]        op;
  logic [2:0]        cmd;
  word_t             data;
  logic [3:0]        bcnt;
  logic              last;
  blk_t              hmask, mmask, hsum, msum, blkbuf, work;
  logic [3:0]        pos;
  logic              hpart, mpart, begun, mismatch, match;
  logic [3:0]        tpos;
  logic [7:0]        nbytes;
  logic [3:0]        idx;
  logic [RoundW-1:0] rnd;
  logic [2:0]        qk;
  logic              half;
  logic              inv;
  logic [1:0]        cnt;
  logic              ovalid;
  out_item_t         oitem;

  logic [3:0]  eff;
  logic [7:0]  nsum;
  blk_t        mm_g, pad_blk, qblk, init_blk;
  logic [2:0]  keff;
  logic [3:0]  i0, i1, i2, i3;
  word_t       ra, rb, rc, rd;
  out_item_t   item;
  logic        emit_go;
  logic        mism_n;
  logic [3:0]  tpos_next;

  always_comb begin
    eff     = last ? ((bcnt > 4'd8) ? 4'd8 : bcnt) : 4'd8;
    nsum    = {1'b0, pos, 3'b000} + {4'b0000, eff};
    mm_g    = (cmd != CMD_HDR && !begun) ? gamma(mmask) : mmask;
    pad_blk = pad(blkbuf, nbytes);
    for (int i = 0; i < 16; i++) begin
      qblk[i] = (8'(8 * i) < nbytes)
              ? ((work[i] ^ mmask[i] ^ pad_blk[i]) & byte_mask(word_bytes(nbytes, 4'(i))))
              : '0;
    end
    qblk[nbytes[6:3]][{nbytes[2:0], 3'b000}] = 1'b1;

    init_blk     = '0;
    init_blk[0]  = cfg.nonce[0];
    init_blk[1]  = cfg.nonce[1];
    init_blk[10] = 64'(DOUBLE_ROUNDS);
    init_blk[11] = 64'(64 * TAG_WORDS);
    for (int i = 0; i < 4; i++) init_blk[12 + i] = cfg.key[i];

    keff = inv ? (qk ^ 3'd4) : qk;
    i0   = qidx(keff, 2'd0);
    i1   = qidx(keff, 2'd1);
    i2   = qidx(keff, 2'd2);
    i3   = qidx(keff, 2'd3);

    mism_n    = ((tpos == 4'd0) ? 1'b0 : mismatch) | (data != hsum[tpos]);
    tpos_next = (tpos == 4'(TAG_WORDS - 1)) ? 4'd0 : tpos + 4'd1;
  end

  opp_round u_round (
    .a(work[i0]), .b(work[i1]), .c(work[i2]), .d(work[i3]),
    .inv(inv), .hi(half ^ inv),
    .a_o(ra), .b_o(rb), .c_o(rc), .d_o(rd)
  );

  always_comb begin
    item = '0;
    unique case (op)
      OP_MFULL: begin
        item.out_word    = work[idx] ^ mmask[idx];
        item.out_bytes   = 4'd8;
        item.result_kind = KIND_DATA;
        item.last_result = (idx == 4'd15);
      end
      OP_MPART: begin
        item.out_bytes   = word_bytes(nbytes, idx);
        item.out_word    = (work[idx] ^ mmask[idx] ^ pad_blk[idx])
                         & byte_mask(item.out_bytes);
        item.result_kind = KIND_DATA;
        item.last_result = ({1'b0, idx, 3'b000} + 8'd8) >= nbytes;
      end
      OP_FIN: begin
        item.out_word    = hsum[idx];
        item.out_bytes   = 4'd8;
        item.result_kind = KIND_TAG;
        item.last_result = (idx == 4'(TAG_WORDS - 1));
      end
      OP_TCHK: begin
        item.result_kind = KIND_CHECK;
        item.tag_match   = match;
        item.last_result = 1'b1;
      end
      default: item.last_result = 1'b1;
    endcase
  end

  assign emit_go     = (state == S_EMIT) && (!ovalid || out_ch.ready);
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ovalid   <= 1'b0;
      hmask    <= '0;
      mmask    <= '0;
      hsum     <= '0;
      msum     <= '0;
      pos      <= '0;
      hpart    <= 1'b0;
      mpart    <= 1'b0;
      begun    <= 1'b0;
      mismatch <= 1'b0;
      tpos     <= '0;
    end else begin
      if (emit_go) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (cmd) inside
            CMD_START: begin
              work  <= init_blk;
              op    <= OP_START;
              inv   <= 1'b0;
              rnd   <= '0;
              qk    <= '0;
              half  <= 1'b0;
              state <= S_PERM;
            end
            CMD_HDR, CMD_ENC, CMD_DEC: begin
              if (cmd != CMD_HDR) begin
                begun <= 1'b1;
              end
              mmask       <= (last && nsum != 8'd128 && nsum != 8'd0 && cmd != CMD_HDR)
                           ? beta(mm_g) : mm_g;
              blkbuf[pos] <= data & byte_mask(eff);
              if (nsum == 8'd128) begin
                op    <= (cmd == CMD_HDR) ? OP_HFULL : OP_MFULL;
                pos   <= '0;
                state <= S_LOAD;
                if (last) begin
                  if (cmd == CMD_HDR) hpart <= 1'b0;
                  else mpart <= 1'b0;
                end
              end else if (last) begin
                pos <= '0;
                if (cmd == CMD_HDR) hpart <= (nsum != 8'd0);
                else mpart <= (nsum != 8'd0);
                if (nsum != 8'd0) begin
                  nbytes <= nsum;
                  state  <= S_LOAD;
                  if (cmd == CMD_HDR) begin
                    op    <= OP_HPART;
                    hmask <= beta(hmask);
                  end else begin
                    op    <= OP_MPART;
                  end
                end else begin
                  state <= S_IDLE;
                end
              end else begin
                pos   <= pos + 4'd1;
                state <= S_IDLE;
              end
            end
            CMD_FIN: begin
              cnt      <= 2'd2 + {1'b0, mpart} - {1'b0, hpart};
              pos      <= '0;
              tpos     <= '0;
              mismatch <= 1'b0;
              op       <= OP_FIN;
              state    <= S_BETA;
            end
            CMD_TAG: begin
              mismatch <= mism_n;
              match    <= !mism_n;
              tpos     <= tpos_next;
              op       <= OP_TCHK;
              idx      <= '0;
              state    <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_BETA: begin
          hmask <= beta(hmask);
          cnt   <= cnt - 2'd1;
          if (cnt == 2'd1) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          unique case (op)
            OP_HFULL: work <= blkbuf ^ hmask;
            OP_MFULL: work <= blkbuf ^ mmask;
            OP_HPART: work <= pad_blk ^ hmask;
            OP_MPART: work <= mmask;
            default:  work <= msum ^ hmask;
          endcase
          inv   <= (op == OP_MFULL) && (cmd == CMD_DEC);
          rnd   <= '0;
          qk    <= '0;
          half  <= 1'b0;
          state <= S_PERM;
        end
        S_PERM: begin
          work[i0] <= ra;
          work[i1] <= rb;
          work[i2] <= rc;
          work[i3] <= rd;
          half     <= ~half;
          if (half) begin
            qk <= qk + 3'd1;
            if (qk == 3'd7) begin
              rnd <= rnd + RoundW'(1);
              if (rnd == RoundW'(DOUBLE_ROUNDS - 1)) begin
                state <= S_POST;
              end
            end
          end
        end
        S_POST: begin
          idx <= '0;
          unique case (op)
            OP_START: begin
              hmask    <= work;
              mmask    <= work;
              hsum     <= '0;
              msum     <= '0;
              pos      <= '0;
              hpart    <= 1'b0;
              mpart    <= 1'b0;
              begun    <= 1'b0;
              mismatch <= 1'b0;
              tpos     <= '0;
              state    <= S_IDLE;
            end
            OP_HFULL: begin
              hsum  <= hsum ^ work ^ hmask;
              hmask <= alpha(hmask);
              state <= S_IDLE;
            end
            OP_HPART: begin
              hsum  <= hsum ^ work ^ hmask;
              state <= S_IDLE;
            end
            OP_MFULL: begin
              msum  <= msum ^ ((cmd == CMD_ENC) ? blkbuf : (work ^ mmask));
              state <= S_EMIT;
            end
            OP_MPART: begin
              msum  <= msum ^ ((cmd == CMD_ENC) ? pad_blk : qblk);
              state <= S_EMIT;
            end
            OP_FIN: begin
              msum  <= work;
              hsum  <= hsum ^ work ^ hmask;
              state <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_EMIT: begin
          if (emit_go) begin
            if (item.last_result) begin
              state <= S_IDLE;
              if (op == OP_MFULL) begin
                mmask <= alpha(mmask);
              end
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latch the transferred item and the result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd  <= in_ch.cmd;
      data <= in_ch.data_word;
      bcnt <= in_ch.byte_count;
      last <= in_ch.last_word;
    end
    if (emit_go) begin
      oitem <= item;
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.out_word    = oitem.out_word;
  assign out_ch.out_bytes   = oitem.out_bytes;
  assign out_ch.result_kind = oitem.result_kind;
  assign out_ch.tag_match   = oitem.tag_match;
  assign out_ch.last_result = oitem.last_result;

endmodule

// ===== rtl/core/masked_permutation_aead_engine_top.sv =====
// Top level: APB key/nonce registers, engine core and port checks.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        cmd, data_word, byte_count, last_word
//   out_ch    out        valid/ready        out_word, out_bytes, result_kind,
//                                           tag_match, last_result
//   apb       in         psel/penable       key_word_0..3, nonce_word_0..1 at 8*i
//
// A word that leaves its block open goes through decode and back to idle. A closing
// block or a start runs the permutation in the shared half quarter-round unit after
// its decode and setup steps, then a post step; results go out one per cycle while
// the receiver is ready. Finalise adds 1 to 3 mask steps. Reset is synchronous and
// clears control, masks and sums. A stalled result holds the sequencer in its emit
// step; the last result of an item may wait while the next item is taken.
`include "masked_permutation_aead_engine_top_defines.svh"

module masked_permutation_aead_engine_top import opp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  opp_in_if.sink      in_ch,
  opp_out_if.source   out_ch
);

  cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_KEY0:   cfg.key[0]   <= pwdata;
        REG_KEY1:   cfg.key[1]   <= pwdata;
        REG_KEY2:   cfg.key[2]   <= pwdata;
        REG_KEY3:   cfg.key[3]   <= pwdata;
        REG_NONCE0: cfg.nonce[0] <= pwdata;
        REG_NONCE1: cfg.nonce[1] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_KEY0:   prdata = cfg.key[0];
      REG_KEY1:   prdata = cfg.key[1];
      REG_KEY2:   prdata = cfg.key[2];
      REG_KEY3:   prdata = cfg.key[3];
      REG_NONCE0: prdata = cfg.nonce[0];
      REG_NONCE1: prdata = cfg.nonce[1];
      default:    prdata = '0;
    endcase
  end

  opp_core u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  `OPP_ASSERT(a_busy_after_transfer, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "ready after transfer")
  `OPP_ASSERT_RST(a_reset_clears_out, rst |=> !out_ch.valid, "result valid after reset")
  `OPP_ASSERT(a_check_payload, (out_ch.valid && out_ch.result_kind == KIND_CHECK) |-> (out_ch.out_word == '0 && out_ch.out_bytes == 4'd0 && out_ch.last_result), "bad check result")
  `OPP_ASSERT(a_match_only_check, (out_ch.valid && out_ch.result_kind != KIND_CHECK) |-> !out_ch.tag_match, "match on data or tag")

endmodule

// ===== test/aead_checker.sv =====
// Checker for the masked permutation AEAD engine: predicts results and compares transfers.
module aead_checker import opp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  opp_in_if           in_mon,
  opp_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fails,
  output int          pending,
  output word_t [3:0] tag_now
);

  word_t [3:0] key_r;
  word_t [1:0] nonce_r;
  blk_t hdr_mask, msg_mask, hdr_sum, msg_sum, blk_buf;
  int unsigned word_pos, tag_pos, last_bytes;
  bit hdr_part, msg_part, msg_begun, tag_bad;
  out_item_t expected_q[$];

  function automatic word_t ror(word_t x, int c);
    return (x >> c) | (x << (64 - c));
  endfunction

  function automatic word_t rol(word_t x, int c);
    return (x << c) | (x >> (64 - c));
  endfunction

  // state index of lane j in column (k < 4) or diagonal step k
  function automatic int lane(int k, int j);
    return (k < 4) ? (k + 4 * j) : (4 * j + ((k - 4 + j) & 3));
  endfunction

  function automatic blk_t mix(blk_t s, int k, bit inv);
    word_t a, b, c, d;
    a = s[lane(k, 0)]; b = s[lane(k, 1)]; c = s[lane(k, 2)]; d = s[lane(k, 3)];
    if (!inv) begin
      a = a + b; d = ror(d ^ a, 32);
      c = c + d; b = ror(b ^ c, 24);
      a = a + b; d = ror(d ^ a, 16);
      c = c + d; b = ror(b ^ c, 63);
    end else begin
      b = rol(b, 63) ^ c; c = c - d;
      d = rol(d, 16) ^ a; a = a - b;
      b = rol(b, 24) ^ c; c = c - d;
      d = rol(d, 32) ^ a; a = a - b;
    end
    s[lane(k, 0)] = a; s[lane(k, 1)] = b; s[lane(k, 2)] = c; s[lane(k, 3)] = d;
    return s;
  endfunction

  function automatic blk_t permute(blk_t s, bit inv);
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      if (!inv) begin
        for (int k = 0; k < 8; k++) s = mix(s, k, 1'b0);
      end else begin
        for (int k = 4; k < 8; k++) s = mix(s, k, 1'b1);
        for (int k = 0; k < 4; k++) s = mix(s, k, 1'b1);
      end
    end
    return s;
  endfunction

  function automatic word_t fold(blk_t m, int a, int b);
    return rol(m[a], 53) ^ (m[b] << 13);
  endfunction

  function automatic blk_t step_alpha(blk_t m);
    blk_t r;
    for (int i = 0; i < 15; i++) r[i] = m[i + 1];
    r[15] = fold(m, 0, 5);
    return r;
  endfunction

  function automatic blk_t step_beta(blk_t m);
    blk_t r;
    for (int i = 0; i < 15; i++) r[i] = m[i] ^ m[i + 1];
    r[15] = m[15] ^ fold(m, 0, 5);
    return r;
  endfunction

  function automatic blk_t step_gamma(blk_t m);
    blk_t r;
    word_t t0, t1;
    t0 = fold(m, 0, 5);
    t1 = fold(m, 1, 6);
    for (int i = 0; i < 14; i++) r[i] = m[i] ^ m[i + 1] ^ m[i + 2];
    r[14] = m[14] ^ m[15] ^ t0;
    r[15] = m[15] ^ t0 ^ t1;
    return r;
  endfunction

  function automatic word_t low_bytes(int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  task automatic push(word_t w, int unsigned nb, logic [1:0] kind, bit match, bit fin);
    out_item_t e;
    e.out_word = w;
    e.out_bytes = 4'(nb);
    e.result_kind = kind;
    e.tag_match = match;
    e.last_result = fin;
    expected_q.push_back(e);
  endtask

  task automatic close_full(logic [2:0] cmd);
    blk_t b;
    word_t w;
    if (cmd == CMD_HDR) begin
      b = permute(blk_buf ^ hdr_mask, 1'b0);
      hdr_sum = hdr_sum ^ b ^ hdr_mask;
      hdr_mask = step_alpha(hdr_mask);
    end else begin
      b = permute(blk_buf ^ msg_mask, cmd != CMD_ENC);
      for (int i = 0; i < 16; i++) begin
        w = b[i] ^ msg_mask[i];
        msg_sum[i] ^= (cmd == CMD_ENC) ? blk_buf[i] : w;
        push(w, 8, KIND_DATA, 1'b0, i == 15);
      end
      msg_mask = step_alpha(msg_mask);
    end
  endtask

  task automatic close_partial(logic [2:0] cmd, int unsigned n);
    blk_t p, b, q;
    int unsigned nw, nb;
    nw = (n + 7) / 8;
    for (int i = 0; i < 16; i++) p[i] = (i * 8 < n) ? blk_buf[i] : '0;
    p[(n >> 3) & 15][8 * (n & 7)] = 1'b1;
    if (cmd == CMD_HDR) begin
      hdr_mask = step_beta(hdr_mask);
      b = permute(p ^ hdr_mask, 1'b0);
      hdr_sum = hdr_sum ^ b ^ hdr_mask;
    end else begin
      msg_mask = step_beta(msg_mask);
      b = permute(msg_mask, 1'b0);
      if (cmd == CMD_ENC) begin
        msg_sum = msg_sum ^ p;
      end else begin
        for (int i = 0; i < 16; i++)
          q[i] = (i < nw) ? ((b[i] ^ msg_mask[i] ^ p[i]) & low_bytes(n - 8 * i)) : '0;
        q[(n >> 3) & 15][8 * (n & 7)] = 1'b1;
        msg_sum = msg_sum ^ q;
      end
      for (int i = 0; i < nw; i++) begin
        nb = (n - 8 * i > 8) ? 8 : n - 8 * i;
        push((b[i] ^ msg_mask[i] ^ p[i]) & low_bytes(nb), nb, KIND_DATA, 1'b0, i + 1 == nw);
      end
    end
  endtask

  task automatic predict(logic [2:0] cmd, word_t data, logic [3:0] bc, logic fin);
    int unsigned eff, pos, n, tp;
    case (cmd)
      CMD_START: begin
        hdr_mask = '0;
        hdr_mask[0] = nonce_r[0];
        hdr_mask[1] = nonce_r[1];
        hdr_mask[10] = DOUBLE_ROUNDS;
        hdr_mask[11] = 64 * TAG_WORDS;
        for (int i = 0; i < 4; i++) hdr_mask[12 + i] = key_r[i];
        hdr_mask = permute(hdr_mask, 1'b0);
        msg_mask = hdr_mask;
        hdr_sum = '0; msg_sum = '0;
        word_pos = 0; hdr_part = 0; msg_part = 0; msg_begun = 0;
        tag_bad = 0; tag_pos = 0; last_bytes = 0;
      end
      CMD_HDR, CMD_ENC, CMD_DEC: begin
        eff = fin ? ((bc > 8) ? 8 : bc) : 8;
        pos = word_pos & 15;
        n = pos * 8 + eff;
        if (cmd != CMD_HDR && !msg_begun) begin
          msg_mask = step_gamma(msg_mask);
          msg_begun = 1;
        end
        blk_buf[pos] = data & low_bytes(eff);
        if (fin) last_bytes = eff;
        if (n == 128) begin
          close_full(cmd);
          word_pos = 0;
          if (fin) begin
            if (cmd == CMD_HDR) hdr_part = 0; else msg_part = 0;
          end
        end else if (fin) begin
          if (n > 0) close_partial(cmd, n);
          if (cmd == CMD_HDR) hdr_part = (n > 0); else msg_part = (n > 0);
          word_pos = 0;
        end else begin
          word_pos = pos + 1;
        end
      end
      CMD_FIN: begin
        for (int i = 0; i < 2 + int'(msg_part) - int'(hdr_part); i++)
          hdr_mask = step_beta(hdr_mask);
        msg_sum = permute(msg_sum ^ hdr_mask, 1'b0);
        hdr_sum = hdr_sum ^ msg_sum ^ hdr_mask;
        for (int i = 0; i < TAG_WORDS; i++)
          push(hdr_sum[i & 15], 8, KIND_TAG, 1'b0, i + 1 == TAG_WORDS);
        word_pos = 0; tag_pos = 0; tag_bad = 0;
      end
      CMD_TAG: begin
        tp = tag_pos % TAG_WORDS;
        if (tp == 0) tag_bad = 0;
        if (data != hdr_sum[tp & 15]) tag_bad = 1;
        tag_pos = (tp + 1) % TAG_WORDS;
        push('0, 0, KIND_CHECK, !tag_bad, 1'b1);
      end
      default: ;
    endcase
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      key_r = '0; nonce_r = '0;
      hdr_mask = '0; msg_mask = '0; hdr_sum = '0; msg_sum = '0; blk_buf = '0;
      word_pos = 0; tag_pos = 0; last_bytes = 0;
      hdr_part = 0; msg_part = 0; msg_begun = 0; tag_bad = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_KEY0:   key_r[0] = pwdata;
          REG_KEY1:   key_r[1] = pwdata;
          REG_KEY2:   key_r[2] = pwdata;
          REG_KEY3:   key_r[3] = pwdata;
          REG_NONCE0: nonce_r[0] = pwdata;
          REG_NONCE1: nonce_r[1] = pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict(in_mon.cmd, in_mon.data_word, in_mon.byte_count, in_mon.last_word);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word=%h bytes=%0d kind=%0d match=%b last=%b",
                   $time, out_mon.out_word, out_mon.out_bytes, out_mon.result_kind,
                   out_mon.tag_match, out_mon.last_result);
        end else begin
          e = expected_q.pop_front();
          if (out_mon.out_word !== e.out_word || out_mon.out_bytes !== e.out_bytes ||
              out_mon.result_kind !== e.result_kind || out_mon.tag_match !== e.tag_match ||
              out_mon.last_result !== e.last_result) begin
            fails++;
            $display("%0t: mismatch expected word=%h bytes=%0d kind=%0d match=%b last=%b",
                     $time, e.out_word, e.out_bytes, e.result_kind, e.tag_match,
                     e.last_result);
            $display("%0t:          actual word=%h bytes=%0d kind=%0d match=%b last=%b",
                     $time, out_mon.out_word, out_mon.out_bytes, out_mon.result_kind,
                     out_mon.tag_match, out_mon.last_result);
          end
        end
      end
    end
    pending = expected_q.size();
    tag_now = hdr_sum[3:0];
  end

endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, stimulus, register writes and the final verdict.
module tb;
  import opp_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 200;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          fails, pending;
  word_t [3:0] tag_now;
  int          cycles;
  int          sent;
  int          stall_left;
  bit          lively;
  bit          calm;

  opp_in_if  in_ch();
  opp_out_if out_ch();

  masked_permutation_aead_engine_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  aead_checker chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending), .tag_now(tag_now)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (!calm && lively && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(1, 19);
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end
  end

  function automatic word_t rnd_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send(logic [2:0] cmd, word_t data, logic [3:0] bc, logic fin);
    if (!calm && lively && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.data_word <= data;
    in_ch.byte_count <= bc;
    in_ch.last_word <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, word_t val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [3:0] end_bytes();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
  endfunction

  // send a run of words with the final one marked last
  task automatic words(logic [2:0] cmd, int count);
    logic [2:0] c;
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7)) : cmd;
      if (i == count - 1) send(c, rnd_word(), end_bytes(), 1'b1);
      else send(c, rnd_word(), 4'($urandom_range(0, 15)), 1'b0);
    end
  endtask

  task automatic check_tag(bit good, int count);
    word_t w;
    for (int i = 0; i < count; i++) begin
      w = tag_now[i % TAG_WORDS];
      if (!good && $urandom_range(0, 2) == 0) w[$urandom_range(0, 63)] ^= 1'b1;
      send(CMD_TAG, w, 4'd8, 1'b0);
    end
  endtask

  task automatic session(bit hold_back);
    int nh, nm;
    nh = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 18);
    nm = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 18);
    send(CMD_START, rnd_word(), 4'($urandom_range(0, 15)), 1'($urandom));
    words(CMD_HDR, nh);
    words($urandom_range(0, 1) ? CMD_ENC : CMD_DEC, nm);
    if (hold_back) drain();
    send(CMD_FIN, rnd_word(), 4'($urandom_range(0, 15)), 1'($urandom));
    check_tag($urandom_range(0, 1), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 4);
  endtask

  initial begin
    int round;
    cycles = 0;
    sent = 0;
    stall_left = 0;
    lively = 1'b1;
    calm = 1'b0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.cmd = CMD_START; in_ch.data_word = '0;
    in_ch.byte_count = '0; in_ch.last_word = 1'b0;
    out_ch.ready = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    reg_write(REG_KEY0, '1);
    reg_write(REG_KEY1, '1);
    reg_write(REG_KEY2, '1);
    reg_write(REG_KEY3, '1);
    reg_write(REG_NONCE0, '1);
    reg_write(REG_NONCE1, '1);
    send(CMD_START, '0, 4'd0, 1'b0);
    send(CMD_HDR, '1, 4'd8, 1'b1);
    for (int i = 0; i < 16; i++) send(CMD_ENC, (i == 0) ? '0 : '1, 4'd15, i == 15);
    send(CMD_FIN, '0, 4'd0, 1'b0);
    check_tag(1'b1, 4);
    drain();
    reg_write(REG_KEY0, '0);
    reg_write(REG_NONCE1, '0);
    send(CMD_START, '1, 4'd15, 1'b1);
    send(CMD_ENC, '1, 4'd0, 1'b1);
    send(CMD_DEC, '1, 4'd8, 1'b0);
    send(CMD_DEC, '1, 4'd5, 1'b1);
    send(3'd6, '1, 4'd15, 1'b1);
    send(3'd7, '0, 4'd0, 1'b0);
    send(CMD_HDR, 64'h8000_0000_0000_0001, 4'd9, 1'b1);
    send(CMD_FIN, '1, 4'd15, 1'b1);
    send(CMD_TAG, '1, 4'd0, 1'b1);
    drain();

    round = 0;
    while (sent < 320) begin
      if (sent > 260) calm = 1'b1;
      lively = ($urandom_range(0, 3) != 0);
      if (round % 4 == 1) begin
        reg_write(REG_KEY0, rnd_word());
        reg_write(REG_KEY1, rnd_word());
        reg_write(REG_KEY2, '0);
        reg_write(REG_KEY3, rnd_word());
      end
      reg_write(REG_NONCE0, (round == 2) ? '0 : rnd_word());
      reg_write(REG_NONCE1, (round == 2) ? '1 : rnd_word());
      session(round == 3);
      drain();
      round++;
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/opp_pkg.sv
rtl/core/opp_if.sv
rtl/core/opp_round.sv
rtl/core/opp_core.sv
rtl/core/masked_permutation_aead_engine_top.sv
test/aead_checker.sv
test/tb.sv
